// ----- rtl/anui_pkg.sv -----
// ----------------------------------------------------------------------------
// anui_pkg: shared types and constants of the Annex-B NAL unit indexer
// Input word, result word and the event word passed from front to back.
// ----------------------------------------------------------------------------
`default_nettype none

package anui_pkg;

  localparam int unsigned POS_BITS = 24;
  localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

  localparam logic [4:0] NAL_TYPE_MASK = 5'h1F;
  localparam logic [4:0] NAL_TYPE_SPS  = 5'd7;
  localparam logic [4:0] NAL_TYPE_PPS  = 5'd8;

  localparam logic [7:0] BYTE_ZERO = 8'h00;
  localparam logic [7:0] BYTE_ONE  = 8'h01;

  typedef logic [POS_BITS-1:0] pos_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       segment_last;
    logic       key_frame;
  } in_item_t;

  typedef struct packed {
    logic       nal_valid;
    logic [23:0] nal_offset;
    logic [23:0] nal_length;
    logic [4:0] nal_type;
    logic       have_param_sets;
    logic       segment_end;
    logic       frame_key;
    logic       length_overflow;
  } result_t;

  // one event per byte that closes a NAL or ends the segment
  typedef struct packed {
    logic       closing;     // a NAL was open and ends here
    pos_t       end_pos;
    pos_t       begin_pos;
    logic [4:0] nal_type;
    logic       seg_last;
    logic       key;
    logic       ovf;
  } event_t;

endpackage

`default_nettype wire

// ----- rtl/anui_front.sv -----
// ----------------------------------------------------------------------------
// anui_front: byte classifier
// Tracks byte position, zero run and start codes; emits one event per byte
// that closes a NAL unit or ends the segment.
// ----------------------------------------------------------------------------
`default_nettype none

module anui_front import anui_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     byte_vld_i,
  input  wire in_item_t byte_i,
  output event_t        evt_o,
  output logic          evt_vld_o
);

  pos_t       pos_q, pos_d;
  logic [1:0] zrun_q, zrun_d;
  logic       inside_q, inside_d;
  pos_t       begin_q, begin_d;
  logic       tpend_q, tpend_d;
  logic [4:0] ctype_q, ctype_d;
  logic       ovf_q, ovf_d;

  logic       at_max;
  logic       is_start;
  logic [4:0] type_now;
  pos_t       pos_inc;
  pos_t       start_end;

  always_comb begin
    at_max    = (pos_q == POS_MAX);
    pos_inc   = at_max ? POS_MAX : pos_q + pos_t'(1);
    type_now  = tpend_q ? (byte_i.data_byte[4:0] & NAL_TYPE_MASK) : ctype_q;
    is_start  = (byte_i.data_byte == BYTE_ONE) && zrun_q[1];
    // start code zeros (two or three) are cut from the closing NAL
    start_end = (pos_q >= pos_t'(zrun_q)) ? pos_q - pos_t'(zrun_q) : '0;

    evt_o.closing   = inside_q;
    evt_o.end_pos   = is_start ? start_end : pos_inc;
    evt_o.begin_pos = begin_q;
    evt_o.nal_type  = type_now;
    evt_o.seg_last  = byte_i.segment_last;
    evt_o.key       = byte_i.key_frame;
    evt_o.ovf       = ovf_q | at_max;
    evt_vld_o       = byte_vld_i && ((is_start && inside_q) || byte_i.segment_last);

    pos_d    = pos_inc;
    ovf_d    = ovf_q | at_max;
    ctype_d  = type_now;
    tpend_d  = is_start;
    inside_d = inside_q | is_start;
    begin_d  = is_start ? pos_inc : begin_q;
    if (byte_i.data_byte == BYTE_ZERO) begin
      zrun_d = (zrun_q == 2'd3) ? zrun_q : zrun_q + 2'd1;
    end else begin
      zrun_d = '0;
    end

    if (byte_i.segment_last) begin
      pos_d    = '0;
      ovf_d    = 1'b0;
      ctype_d  = '0;
      tpend_d  = 1'b0;
      inside_d = 1'b0;
      begin_d  = '0;
      zrun_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      zrun_q   <= '0;
      inside_q <= 1'b0;
      begin_q  <= '0;
      tpend_q  <= 1'b0;
      ctype_q  <= '0;
      ovf_q    <= 1'b0;
    end else if (byte_vld_i) begin
      pos_q    <= pos_d;
      zrun_q   <= zrun_d;
      inside_q <= inside_d;
      begin_q  <= begin_d;
      tpend_q  <= tpend_d;
      ctype_q  <= ctype_d;
      ovf_q    <= ovf_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/anui_evq.sv -----
// ----------------------------------------------------------------------------
// anui_evq: two-entry event queue
// Decouples the byte classifier from the descriptor builder.
// ----------------------------------------------------------------------------
`default_nettype none

module anui_evq import anui_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   push_i,
  input  wire event_t data_i,
  output logic        full_o,
  output logic        vld_o,
  input  wire logic   pop_i,
  output event_t      data_o
);

  event_t     mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign vld_o   = (cnt_q != 2'd0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && vld_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= ~wr_q;
      if (do_pop)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

`default_nettype wire

// ----- rtl/anui_back.sv -----
// ----------------------------------------------------------------------------
// anui_back: descriptor builder
// Turns events into result words, keeps the sticky parameter-set flag and
// holds finished results in a two-entry output queue.
// ----------------------------------------------------------------------------
`default_nettype none

module anui_back import anui_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   evt_vld_i,
  input  wire event_t evt_i,
  output logic        evt_pop_o,
  output logic        empty_o,
  input  wire logic   pop_i,
  output result_t     res_o
);

  result_t    buf_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       psets_q;
  logic       emit;
  logic       psets_now;
  result_t    res_new;
  logic       do_pop;

  always_comb begin
    emit      = evt_i.closing && (evt_i.end_pos > evt_i.begin_pos);
    psets_now = psets_q | (emit && (evt_i.nal_type == NAL_TYPE_PPS));

    res_new.nal_valid       = emit;
    res_new.nal_offset      = emit ? evt_i.begin_pos : '0;
    res_new.nal_length      = emit ? evt_i.end_pos - evt_i.begin_pos : '0;
    res_new.nal_type        = emit ? evt_i.nal_type : '0;
    res_new.have_param_sets = psets_now;
    res_new.segment_end     = evt_i.seg_last;
    res_new.frame_key       = evt_i.key;
    res_new.length_overflow = evt_i.ovf;
  end

  assign empty_o   = (cnt_q == 2'd0);
  assign res_o     = buf_q[rd_q];
  assign do_pop    = pop_i && !empty_o;
  assign evt_pop_o = evt_vld_i && ((cnt_q != 2'd2) || do_pop);

  // a start-code event with an empty NAL and no segment end carries nothing
  logic store;
  assign store = evt_pop_o && (emit || evt_i.seg_last);

  always_ff @(posedge clk_i) begin
    if (store) begin
      buf_q[wr_q] <= res_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= 1'b0;
      rd_q    <= 1'b0;
      cnt_q   <= '0;
      psets_q <= 1'b0;
    end else begin
      if (store)  wr_q <= ~wr_q;
      if (do_pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, store} - {1'b0, do_pop};
      if (evt_pop_o) psets_q <= psets_now;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/annexb_nal_unit_indexer.sv -----
// ----------------------------------------------------------------------------
// annexb_nal_unit_indexer: Annex-B NAL unit indexer
// Takes one Annex-B byte per cycle and gives one descriptor per NAL unit
// (offset, length for the AVCC prefix, type) plus an end-of-segment word.
//
// Input side is a queue: push with item_i is taken when full is low.
// One byte per cycle is sustained while full is low; a byte never waits
// on its own result. Result side is a queue: result_o holds the oldest
// word while empty is low and pop takes it. A descriptor passes through
// the event queue and the output queue after the byte that closes the NAL
// (the 01 of the next start code or the segment's last byte); the last byte
// always yields a word, nal_valid=0 if nothing closed. Throughput: one byte
// per cycle while full is low; the event queue and output queue each hold
// two words. When pop stays low the output queue fills, then the event
// queue, then full rises. Reset clears all segment state, the sticky
// parameter-set flag and both queues. Offsets count from the segment's
// first byte and saturate at 2^24-1, flagged by length_overflow.
// ----------------------------------------------------------------------------
`default_nettype none

module annexb_nal_unit_indexer import anui_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push,
  input  wire in_item_t item_i,
  output logic          full,
  output logic          empty,
  input  wire logic     pop,
  output result_t       result_o
);

  event_t evt_in, evt_out;
  logic   evt_push, evt_full, evt_vld, evt_pop;
  logic   byte_vld;

  assign byte_vld = push && !full;
  assign full     = evt_full;

  anui_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .byte_vld_i (byte_vld),
    .byte_i     (item_i),
    .evt_o      (evt_in),
    .evt_vld_o  (evt_push)
  );

  anui_evq u_evq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (evt_push),
    .data_i (evt_in),
    .full_o (evt_full),
    .vld_o  (evt_vld),
    .pop_i  (evt_pop),
    .data_o (evt_out)
  );

  anui_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .evt_vld_i (evt_vld),
    .evt_i     (evt_out),
    .evt_pop_o (evt_pop),
    .empty_o   (empty),
    .pop_i     (pop),
    .res_o     (result_o)
  );

endmodule

`default_nettype wire

// ----- rtl/anui_checker.sv -----
// ----------------------------------------------------------------------------
// anui_checker: port-level checks for the NAL unit indexer
// Watches the result channel and flags malformed or unstable words.
// ----------------------------------------------------------------------------
`default_nettype none

module anui_checker import anui_pkg::*; (
  input wire logic     clk_i,
  input wire logic     rst_ni,
  input wire logic     empty,
  input wire logic     pop,
  input wire result_t  result_o
);

  logic psets_seen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      psets_seen_q <= 1'b0;
    end else if (pop && !empty && result_o.have_param_sets) begin
      psets_seen_q <= 1'b1;
    end
  end

  // a waiting word stays put until popped
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(result_o))
    else $error("result word changed while stalled");

  // a word without a NAL only marks the segment end
  a_void_is_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !result_o.nal_valid |-> result_o.segment_end)
    else $error("empty descriptor not at segment end");

  a_void_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !result_o.nal_valid |->
      result_o.nal_offset == '0 && result_o.nal_length == '0 && result_o.nal_type == '0)
    else $error("empty descriptor carries data");

  a_len_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && result_o.nal_valid |-> result_o.nal_length != '0)
    else $error("descriptor with zero length");

  // parameter-set flag never drops once delivered
  a_psets_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && psets_seen_q |-> result_o.have_param_sets)
    else $error("parameter-set flag dropped");

endmodule

bind annexb_nal_unit_indexer anui_checker u_anui_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .empty    (empty),
  .pop      (pop),
  .result_o (result_o)
);

`default_nettype wire
